// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int ELEM_WIDTH   = 32;
  localparam int PRIO_WIDTH   = 16;
  localparam int COUNT_WIDTH  = 5;
  localparam int STATUS_WIDTH = 2;
  localparam int CAPACITY_DEF = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                  cmd;
    logic [ELEM_WIDTH-1:0] elem;
    logic [PRIO_WIDTH-1:0] prio;
  } spq_in_t;

  typedef struct packed {
    logic [ELEM_WIDTH-1:0]   front_elem;
    logic [PRIO_WIDTH-1:0]   front_prio;
    logic                    empty_res;
    logic [COUNT_WIDTH-1:0]  count;
    logic [STATUS_WIDTH-1:0] status;
  } spq_out_t;

  // one queue slot
  typedef struct packed {
    logic                  valid;
    logic [PRIO_WIDTH-1:0] prio;
    logic [ELEM_WIDTH-1:0] elem;
  } spq_entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_op_t;

endpackage

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: takes the new entry, its left neighbour's
// entry (shift right on insert) or its right neighbour's (shift on removal).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::spq_op_t    op,
  input  spq_pkg::spq_entry_t new_ent,
  input  spq_pkg::spq_entry_t left_ent,
  input  logic               left_ins,
  input  spq_pkg::spq_entry_t right_ent,
  output spq_pkg::spq_entry_t ent,
  output spq_pkg::spq_entry_t ent_next,
  output logic               ins
);
  import spq_pkg::*;

  // new entry belongs here or further left: strictly greater keeps FIFO order
  assign ins = !ent.valid || (ent.prio > new_ent.prio);

  always_comb begin
    ent_next = ent;
    if (op.enq) begin
      if (left_ins) begin
        ent_next = left_ent;
      end else if (ins) begin
        ent_next = new_ent;
      end
    end else if (op.deq) begin
      ent_next = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent.prio <= ent_next.prio;
    ent.elem <= ent_next.elem;
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue built as a row of sorting cells.
// ----------------------------------------------------------------------------
// Takes one command beat per clock and returns one result beat per command,
// in the cycle after acceptance, through a single output register; a new beat
// is taken whenever that register is empty or being read in the same cycle.
// Every cell compares its priority with the incoming one in parallel and
// shifts by one place, so the cost per operation does not grow with
// CAPACITY. Equal priorities leave in arrival order. An enqueue into a full
// queue is dropped with status overflow; a dequeue from an empty queue is
// ignored with status underflow. Front fields read zero when empty.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spq_pkg::spq_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  spq_entry_t          ents      [CAPACITY];
  spq_entry_t          ents_next [CAPACITY];
  logic [CAPACITY-1:0] ins;
  spq_entry_t          new_ent;
  spq_entry_t          empty_ent;
  spq_op_t             op;
  logic                accept;
  logic                full;
  logic                empty;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [STATUS_WIDTH-1:0] status_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = ents[CAPACITY-1].valid;
  assign empty    = !ents[0].valid;

  assign op.enq = accept && (in_data.cmd == CMD_ENQ) && !full;
  assign op.deq = accept && (in_data.cmd == CMD_DEQ) && !empty;

  assign new_ent.valid = 1'b1;
  assign new_ent.prio  = in_data.prio;
  assign new_ent.elem  = in_data.elem;

  assign empty_ent = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_ent;
    spq_entry_t right_ent;
    logic       left_ins;

    if (i == 0) begin : g_head
      assign left_ent = empty_ent;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_ent = ents[i-1];
      assign left_ins = ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = empty_ent;
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .left_ins  (left_ins),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .ent_next  (ents_next[i]),
      .ins       (ins[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = STATUS_OK;
    if (op.enq) begin
      count_next = count + CW'(1);
    end else if (op.deq) begin
      count_next = count - CW'(1);
    end
    if (accept && (in_data.cmd == CMD_ENQ) && full) begin
      status_next = STATUS_OVERFLOW;
    end else if (accept && (in_data.cmd == CMD_DEQ) && empty) begin
      status_next = STATUS_UNDERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat reflects the head cell after this operation
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.front_elem <= ents_next[0].valid ? ents_next[0].elem : '0;
      out_data.front_prio <= ents_next[0].valid ? ents_next[0].prio : '0;
      out_data.empty_res  <= !ents_next[0].valid;
      out_data.count      <= COUNT_WIDTH'(count_next);
      out_data.status     <= status_next;
    end
  end

endmodule
